[hw/rtl/mtsc_pkg.sv]
// Package for the maze turn steering controller: field widths, register
// indexes and reset values, navigation codes and the controller/datapath
// command and status words. Depends on nothing.
package mtsc_pkg;

  // Default widths of the range and gyro fields.
  localparam int DIST_WIDTH_DEF = 16;
  localparam int RATE_WIDTH_DEF = 24;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  // Fixed field and register widths.
  localparam int WALL_W  = 15;
  localparam int ANGLE_W = 22;
  localparam int TRATE_W = 19;
  localparam int ACCEL_W = 19;
  localparam int GAIN_W  = 16;
  localparam int DT_W    = 16;
  localparam int HEAD_W  = 32;
  localparam int EFF_W   = 32;
  localparam int CRATE_W = 24;
  // The slewed rate never leaves the span of the turn rate register.
  localparam int SLEW_W  = TRATE_W + 1;

  // Register reset values.
  localparam logic [WALL_W-1:0]  WALL_RST  = 15'd819;
  localparam logic [ANGLE_W-1:0] ANGLE_RST = 22'd1646264;
  localparam logic [TRATE_W-1:0] TRATE_RST = 19'd11520;
  localparam logic [ACCEL_W-1:0] ACCEL_RST = 19'd23040;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd1311;

  // Degree to radian factor, Q0.24, held as a 20-bit signed constant.
  localparam int DEG2RAD_W = 20;
  localparam logic signed [DEG2RAD_W-1:0] DEG2RAD_Q24 = 20'sd292817;

  // Rounding points of the heading increment and of the effort.
  localparam int INC_SHIFT = 28;
  localparam int EFF_SHIFT = 8;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WALL_DISTANCE = 3'd0,
    REG_TURN_ANGLE    = 3'd1,
    REG_TURN_RATE     = 3'd2,
    REG_SLEW_LIMIT    = 3'd3,
    REG_YAW_GAIN      = 3'd4
  } cfg_index_t;

  // Navigation codes as shown on the result channel.
  typedef enum logic [1:0] {
    NAV_START   = 2'd0,
    NAV_FORWARD = 2'd1,
    NAV_LEFT    = 2'd2,
    NAV_RIGHT   = 2'd3
  } nav_mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic first;
    logic mul_b;
    logic mul_c;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic steer;
  } ctrl_status_t;

endpackage

[hw/rtl/mtsc_in_if.sv]
// Input channel of the maze turn steering controller: valid, ready and the
// word of range and gyro fields. Depends on mtsc_pkg for default widths.
interface mtsc_in_if #(
  parameter int DIST_WIDTH = mtsc_pkg::DIST_WIDTH_DEF,
  parameter int RATE_WIDTH = mtsc_pkg::RATE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [DIST_WIDTH-1:0]  front_distance;
  logic signed [DIST_WIDTH-1:0]  left_distance;
  logic signed [DIST_WIDTH-1:0]  right_distance;
  logic signed [RATE_WIDTH-1:0]  gyro_rate;
  logic [mtsc_pkg::DT_W-1:0]     time_step;

  modport source (
    output valid, command, front_distance, left_distance, right_distance,
           gyro_rate, time_step,
    input  ready
  );

  modport sink (
    input  valid, command, front_distance, left_distance, right_distance,
           gyro_rate, time_step,
    output ready
  );
endinterface

[hw/rtl/mtsc_out_if.sv]
// Result channel of the maze turn steering controller: valid, ready and the
// result word. Depends on mtsc_pkg for the field widths.
interface mtsc_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         nav_state;
  logic signed [mtsc_pkg::EFF_W-1:0]   turn_effort;
  logic signed [mtsc_pkg::HEAD_W-1:0]  heading;
  logic signed [mtsc_pkg::CRATE_W-1:0] commanded_rate;

  modport source (
    output valid, nav_state, turn_effort, heading, commanded_rate,
    input  ready
  );

  modport sink (
    input  valid, nav_state, turn_effort, heading, commanded_rate,
    output ready
  );
endinterface

[hw/rtl/mtsc_cfg_if.sv]
// Configuration write channel of the maze turn steering controller:
// valid, ready, register index and write data. Depends on mtsc_pkg.
interface mtsc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mtsc_pkg::CFG_IDX_W-1:0]  index;
  logic [mtsc_pkg::CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

[hw/rtl/mtsc_ctrl.sv]
// Sequencing state machine of the maze turn steering controller. It owns
// the input and output handshakes and issues datapath commands. Uses mtsc_pkg.
module mtsc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  mtsc_pkg::ctrl_status_t status,
  output mtsc_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [4:0] {
    CS_IDLE  = 5'b00001,
    CS_FIRST = 5'b00010,
    CS_MUL_B = 5'b00100,
    CS_MUL_C = 5'b01000,
    CS_FIN   = 5'b10000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = CS_FIRST;
        end
      end
      CS_FIRST: begin
        cmd.first = 1'b1;
        state_nxt = status.steer ? CS_MUL_B : CS_FIN;
      end
      CS_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = CS_MUL_C;
      end
      CS_MUL_C: begin
        cmd.mul_c = 1'b1;
        state_nxt = CS_FIN;
      end
      CS_FIN: begin
        // The result register takes the word once its previous word is gone.
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == CS_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hw/rtl/mtsc_datapath.sv]
// Datapath of the maze turn steering controller: configuration registers,
// navigation state, heading integrator, rate slew and effort multiplier,
// and the result register. Commanded by mtsc_ctrl. Uses mtsc_pkg.
module mtsc_datapath #(
  parameter int DIST_WIDTH = mtsc_pkg::DIST_WIDTH_DEF,
  parameter int RATE_WIDTH = mtsc_pkg::RATE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mtsc_pkg::ctrl_cmd_t                  cmd,
  output mtsc_pkg::ctrl_status_t               status,
  // Configuration writes.
  input  logic                                 cfg_we,
  input  logic [mtsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mtsc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Input word.
  input  logic                                 in_command,
  input  logic signed [DIST_WIDTH-1:0]         in_front_distance,
  input  logic signed [DIST_WIDTH-1:0]         in_left_distance,
  input  logic signed [DIST_WIDTH-1:0]         in_right_distance,
  input  logic signed [RATE_WIDTH-1:0]         in_gyro_rate,
  input  logic [mtsc_pkg::DT_W-1:0]            in_time_step,
  // Result word.
  output logic [1:0]                           out_nav_state,
  output logic signed [mtsc_pkg::EFF_W-1:0]    out_turn_effort,
  output logic signed [mtsc_pkg::HEAD_W-1:0]   out_heading,
  output logic signed [mtsc_pkg::CRATE_W-1:0]  out_commanded_rate
);

  localparam int HEAD_W = mtsc_pkg::HEAD_W;
  localparam int SLEW_W = mtsc_pkg::SLEW_W;
  localparam int DT_W   = mtsc_pkg::DT_W;
  // Gyro times time step, then times the degree to radian factor.
  localparam int P1_W   = RATE_WIDTH + DT_W + 1;
  localparam int RAD_W  = P1_W + mtsc_pkg::DEG2RAD_W;
  localparam int INC_W  = RAD_W + 1 - mtsc_pkg::INC_SHIFT;
  localparam int HSUM_W = ((INC_W > HEAD_W) ? INC_W : HEAD_W) + 1;
  // Slew step: the slew limit times time step, scaled back by 16 bits.
  localparam int SPROD_W = mtsc_pkg::ACCEL_W + DT_W;
  // Rate error and effort product.
  localparam int ERR_W  = ((SLEW_W > RATE_WIDTH) ? SLEW_W : RATE_WIDTH) + 1;
  localparam int EP_W   = ERR_W + mtsc_pkg::GAIN_W + 1;
  localparam int ESH_W  = EP_W + 1 - mtsc_pkg::EFF_SHIFT;
  localparam int ESUM_W = ((ESH_W > mtsc_pkg::EFF_W) ? ESH_W : mtsc_pkg::EFF_W) + 1;
  // Range compare width.
  localparam int CMP_W  = ((DIST_WIDTH > mtsc_pkg::WALL_W) ? DIST_WIDTH
                                                           : mtsc_pkg::WALL_W) + 1;
  localparam int GSUM_W = HEAD_W + 1;

  localparam logic signed [HSUM_W-1:0] HSUM_MAX = {{(HSUM_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [HSUM_W-1:0] HSUM_MIN = {{(HSUM_W-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [ESUM_W-1:0] ESUM_MAX = {{(ESUM_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ESUM_W-1:0] ESUM_MIN = {{(ESUM_W-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [GSUM_W-1:0] GSUM_MAX = {2'b00, {31{1'b1}}};
  localparam logic signed [GSUM_W-1:0] GSUM_MIN = {2'b11, {31{1'b0}}};

  // Configuration registers.
  logic [mtsc_pkg::WALL_W-1:0]  wall_r;
  logic [mtsc_pkg::ANGLE_W-1:0] angle_r;
  logic [mtsc_pkg::TRATE_W-1:0] trate_r;
  logic [mtsc_pkg::ACCEL_W-1:0] accel_r;
  logic [mtsc_pkg::GAIN_W-1:0]  gain_r;

  // Input word registers.
  logic                         cmd_r;
  logic signed [DIST_WIDTH-1:0] front_r, left_r, right_r;
  logic signed [RATE_WIDTH-1:0] gyro_r;
  logic [DT_W-1:0]              dt_r;

  // Block state.
  mtsc_pkg::nav_mode_t       mode_r, mode_nxt;
  logic signed [HEAD_W-1:0]  heading_r, heading_nxt;
  logic signed [HEAD_W-1:0]  goal_heading_r, goal_heading_nxt;
  logic signed [SLEW_W-1:0]  goal_rate_r, goal_rate_nxt;
  logic signed [SLEW_W-1:0]  slewed_r, slewed_nxt;

  // Intermediate products.
  logic signed [P1_W-1:0]            p1_r;
  logic signed [RAD_W-1:0]           rad_r;
  logic [mtsc_pkg::ACCEL_W-1:0]      step_r;
  logic signed [EP_W-1:0]            eprod_r;
  logic [SPROD_W-1:0]                sprod;

  // Result register.
  logic [1:0]                          res_nav_r;
  logic signed [mtsc_pkg::EFF_W-1:0]   res_effort_r;
  logic signed [HEAD_W-1:0]            res_heading_r;
  logic signed [mtsc_pkg::CRATE_W-1:0] res_rate_r;

  // Combinational terms.
  logic signed [RAD_W:0]        rad_rnd;
  logic signed [INC_W-1:0]      inc;
  logic signed [HSUM_W-1:0]     hsum;
  logic signed [HEAD_W-1:0]     hsat;
  logic signed [GSUM_W-1:0]     gsum_left, gsum_right;
  logic signed [HEAD_W-1:0]     goal_left, goal_right;
  logic signed [SLEW_W:0]       slew_up, slew_dn, goal_ext;
  logic signed [ERR_W-1:0]      err;
  logic signed [EP_W:0]         eff_rnd;
  logic signed [ESH_W-1:0]      eff_sh;
  logic signed [ESUM_W-1:0]     eff_ext;
  logic signed [mtsc_pkg::EFF_W-1:0] eff_sat;
  logic signed [CMP_W-1:0]      front_ext, wall_ext;
  logic                         near_wall;
  logic signed [SLEW_W-1:0]     trate_ext;

  assign status.steer = cmd_r;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_r  <= mtsc_pkg::WALL_RST;
      angle_r <= mtsc_pkg::ANGLE_RST;
      trate_r <= mtsc_pkg::TRATE_RST;
      accel_r <= mtsc_pkg::ACCEL_RST;
      gain_r  <= mtsc_pkg::GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtsc_pkg::REG_WALL_DISTANCE: wall_r  <= cfg_data[mtsc_pkg::WALL_W-1:0];
        mtsc_pkg::REG_TURN_ANGLE:    angle_r <= cfg_data[mtsc_pkg::ANGLE_W-1:0];
        mtsc_pkg::REG_TURN_RATE:     trate_r <= cfg_data[mtsc_pkg::TRATE_W-1:0];
        mtsc_pkg::REG_SLEW_LIMIT:    accel_r <= cfg_data[mtsc_pkg::ACCEL_W-1:0];
        mtsc_pkg::REG_YAW_GAIN:      gain_r  <= cfg_data[mtsc_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Heading increment, rounded to Q.20 with ties upward, then saturated.
  assign rad_rnd = (RAD_W+1)'(rad_r) + (RAD_W+1)'(1 << (mtsc_pkg::INC_SHIFT - 1));
  assign inc     = rad_rnd[RAD_W:mtsc_pkg::INC_SHIFT];
  assign hsum    = HSUM_W'(inc) + HSUM_W'(heading_r);
  always_comb begin
    if (hsum > HSUM_MAX) begin
      hsat = {1'b0, {31{1'b1}}};
    end else if (hsum < HSUM_MIN) begin
      hsat = {1'b1, {31{1'b0}}};
    end else begin
      hsat = hsum[HEAD_W-1:0];
    end
  end

  // Turn goals either side of the present heading.
  assign gsum_left  = GSUM_W'(heading_r) + $signed({11'd0, angle_r});
  assign gsum_right = GSUM_W'(heading_r) - $signed({11'd0, angle_r});
  always_comb begin
    if (gsum_left > GSUM_MAX) begin
      goal_left = {1'b0, {31{1'b1}}};
    end else begin
      goal_left = gsum_left[HEAD_W-1:0];
    end
    if (gsum_right < GSUM_MIN) begin
      goal_right = {1'b1, {31{1'b0}}};
    end else begin
      goal_right = gsum_right[HEAD_W-1:0];
    end
  end

  // A valid front reading nearer than the threshold.
  assign front_ext = CMP_W'(front_r);
  assign wall_ext  = $signed(CMP_W'(wall_r));
  assign near_wall = (front_ext > $signed(CMP_W'(0))) && (front_ext < wall_ext);
  assign trate_ext = $signed({1'b0, trate_r});

  // Slew candidates, one step toward the goal rate.
  assign slew_up  = (SLEW_W+1)'(slewed_r) + $signed({2'b00, step_r});
  assign slew_dn  = (SLEW_W+1)'(slewed_r) - $signed({2'b00, step_r});
  assign goal_ext = (SLEW_W+1)'(goal_rate_r);

  // Rate error, and the effort rounded to Q.16 with ties upward, saturated.
  assign err     = ERR_W'(slewed_r) - ERR_W'(gyro_r);
  assign eff_rnd = (EP_W+1)'(eprod_r) + (EP_W+1)'(1 << (mtsc_pkg::EFF_SHIFT - 1));
  assign eff_sh  = eff_rnd[EP_W:mtsc_pkg::EFF_SHIFT];
  assign eff_ext = ESUM_W'(eff_sh);
  always_comb begin
    if (eff_ext > ESUM_MAX) begin
      eff_sat = {1'b0, {31{1'b1}}};
    end else if (eff_ext < ESUM_MIN) begin
      eff_sat = {1'b1, {31{1'b0}}};
    end else begin
      eff_sat = eff_ext[mtsc_pkg::EFF_W-1:0];
    end
  end

  assign sprod = accel_r * dt_r;

  // Next values of the block state.
  always_comb begin
    mode_nxt         = mode_r;
    heading_nxt      = heading_r;
    goal_heading_nxt = goal_heading_r;
    goal_rate_nxt    = goal_rate_r;
    slewed_nxt       = slewed_r;

    // Strategy item: step the navigation machine.
    if (cmd.first && !cmd_r) begin
      unique case (mode_r)
        mtsc_pkg::NAV_START: begin
          mode_nxt = mtsc_pkg::NAV_FORWARD;
        end
        mtsc_pkg::NAV_FORWARD: begin
          goal_rate_nxt = '0;
          if (near_wall) begin
            if (left_r > right_r) begin
              mode_nxt         = mtsc_pkg::NAV_LEFT;
              goal_heading_nxt = goal_left;
              goal_rate_nxt    = trate_ext;
            end else begin
              mode_nxt         = mtsc_pkg::NAV_RIGHT;
              goal_heading_nxt = goal_right;
              goal_rate_nxt    = -trate_ext;
            end
          end
        end
        mtsc_pkg::NAV_LEFT: begin
          if (heading_r >= goal_heading_r) begin
            heading_nxt   = goal_heading_r;
            goal_rate_nxt = '0;
            mode_nxt      = mtsc_pkg::NAV_FORWARD;
          end
        end
        mtsc_pkg::NAV_RIGHT: begin
          if (heading_r <= goal_heading_r) begin
            heading_nxt   = goal_heading_r;
            goal_rate_nxt = '0;
            mode_nxt      = mtsc_pkg::NAV_FORWARD;
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end

    // Steering item, second step: move the commanded rate toward the goal.
    if (cmd.mul_b) begin
      if (slewed_r < goal_rate_r) begin
        slewed_nxt = (slew_up > goal_ext) ? goal_rate_r : slew_up[SLEW_W-1:0];
      end else if (slewed_r > goal_rate_r) begin
        slewed_nxt = (slew_dn < goal_ext) ? goal_rate_r : slew_dn[SLEW_W-1:0];
      end
    end

    // Steering item, third step: integrate the heading.
    if (cmd.mul_c) begin
      heading_nxt = hsat;
    end
  end

  // Block state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= mtsc_pkg::NAV_START;
      heading_r      <= '0;
      goal_heading_r <= '0;
      goal_rate_r    <= '0;
      slewed_r       <= '0;
    end else begin
      mode_r         <= mode_nxt;
      heading_r      <= heading_nxt;
      goal_heading_r <= goal_heading_nxt;
      goal_rate_r    <= goal_rate_nxt;
      slewed_r       <= slewed_nxt;
    end
  end

  // Input word capture and the multiply chain.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r   <= in_command;
      front_r <= in_front_distance;
      left_r  <= in_left_distance;
      right_r <= in_right_distance;
      gyro_r  <= in_gyro_rate;
      dt_r    <= in_time_step;
    end
    if (cmd.first) begin
      p1_r   <= gyro_r * $signed({1'b0, dt_r});
      step_r <= sprod[SPROD_W-1:DT_W];
    end
    if (cmd.mul_b) begin
      rad_r <= p1_r * mtsc_pkg::DEG2RAD_Q24;
    end
    if (cmd.mul_c) begin
      eprod_r <= err * $signed({1'b0, gain_r});
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_nav_r     <= mode_r;
      res_effort_r  <= cmd_r ? eff_sat : '0;
      res_heading_r <= heading_r;
      res_rate_r    <= mtsc_pkg::CRATE_W'(slewed_r);
    end
  end

  assign out_nav_state      = res_nav_r;
  assign out_turn_effort    = res_effort_r;
  assign out_heading        = res_heading_r;
  assign out_commanded_rate = res_rate_r;

endmodule

[hw/rtl/maze_turn_steering_controller.sv]
// Maze turn steering controller. A strategy word passes the controller
// states FIRST and FIN after it is accepted, a steering word FIRST, MUL_B,
// MUL_C and FIN; the result register is loaded in FIN and the input is ready
// again the cycle after, so only one word is in work at a time. A steering
// word runs through the chain of three registered multiplies (gyro by time
// step, by the degree to radian factor, then rate error by gain). A waiting
// result only holds the last step of the next word. Configuration writes are
// taken in every cycle.
// Depends on mtsc_pkg, the three channel interfaces, mtsc_ctrl and
// mtsc_datapath.
module maze_turn_steering_controller #(
  parameter int DIST_WIDTH = mtsc_pkg::DIST_WIDTH_DEF,
  parameter int RATE_WIDTH = mtsc_pkg::RATE_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mtsc_in_if.sink    in_ch,
  mtsc_out_if.source out_ch,
  mtsc_cfg_if.sink   cfg_ch
);

  mtsc_pkg::ctrl_cmd_t    cmd;
  mtsc_pkg::ctrl_status_t status;
  logic                   cfg_we;

  // Configuration writes never stall.
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  mtsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mtsc_datapath #(
    .DIST_WIDTH (DIST_WIDTH),
    .RATE_WIDTH (RATE_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .in_command         (in_ch.command),
    .in_front_distance  (in_ch.front_distance),
    .in_left_distance   (in_ch.left_distance),
    .in_right_distance  (in_ch.right_distance),
    .in_gyro_rate       (in_ch.gyro_rate),
    .in_time_step       (in_ch.time_step),
    .out_nav_state      (out_ch.nav_state),
    .out_turn_effort    (out_ch.turn_effort),
    .out_heading        (out_ch.heading),
    .out_commanded_rate (out_ch.commanded_rate)
  );

endmodule

[hw/rtl/mtsc_checker.sv]
// Port-level checks for the maze turn steering controller, attached to the
// top level by the bind statement at the end. Uses mtsc_pkg widths.
module mtsc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [1:0]                           out_nav_state,
  input logic signed [mtsc_pkg::EFF_W-1:0]    out_turn_effort,
  input logic signed [mtsc_pkg::HEAD_W-1:0]   out_heading,
  input logic signed [mtsc_pkg::CRATE_W-1:0]  out_commanded_rate
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn while stalled");

  // A stalled result word keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_nav_state) && $stable(out_turn_effort)
                                && $stable(out_heading) && $stable(out_commanded_rate))
    else $error("result word changed while stalled");

  // One word at a time: after a word is taken, the input stays closed while it is processed.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input reopened before the word was processed");

  // A new result only appears at the end of processing a word.
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result offered without a word in progress");

endmodule

bind maze_turn_steering_controller mtsc_checker u_mtsc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_nav_state      (out_ch.nav_state),
  .out_turn_effort    (out_ch.turn_effort),
  .out_heading        (out_ch.heading),
  .out_commanded_rate (out_ch.commanded_rate)
);

[dv/maze_turn_steering_controller_tb.sv]
// Self-checking testbench for the maze turn steering controller: a queued
// word driver, a result monitor and a bit-exact predictor of the controller.
// Depends on mtsc_pkg, the three channel interfaces and the top-level RTL.
module maze_turn_steering_controller_tb;

  localparam int DW           = mtsc_pkg::DIST_WIDTH_DEF;
  localparam int RW           = mtsc_pkg::RATE_WIDTH_DEF;
  localparam int IDLE_PCT     = 38;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_WORDS  = 300;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_LEN     = 300;
  localparam int MAX_REPORTS  = 10;

  // Command codes carried in the input word.
  localparam logic CMD_STRATEGY = 1'b0;
  localparam logic CMD_STEER    = 1'b1;

  typedef struct {
    logic                          cmd;
    logic signed [DW-1:0]          front_d;
    logic signed [DW-1:0]          left_d;
    logic signed [DW-1:0]          right_d;
    logic signed [RW-1:0]          gyro;
    logic [mtsc_pkg::DT_W-1:0]     dt;
  } nav_word_t;

  typedef struct {
    mtsc_pkg::nav_mode_t                  nav;
    logic signed [mtsc_pkg::EFF_W-1:0]    effort;
    logic signed [mtsc_pkg::HEAD_W-1:0]   heading;
    logic signed [mtsc_pkg::CRATE_W-1:0]  rate;
  } nav_result_t;

  logic clk;
  logic rst_n;
  logic calm;

  nav_word_t   word_q[$];
  nav_result_t result_q[$];
  nav_word_t   cur_word;
  int          words_left;
  int          words_total;
  int          err_count;
  int          results_seen;
  int          hold_left;
  int          cycle_cnt;

  // Controller state and register copies held by the predictor.
  mtsc_pkg::nav_mode_t          mode_m;
  longint                       head_m;
  longint                       goal_head_m;
  longint                       goal_rate_m;
  longint                       slew_m;
  logic [mtsc_pkg::WALL_W-1:0]  wall_q;
  logic [mtsc_pkg::ANGLE_W-1:0] angle_q;
  logic [mtsc_pkg::TRATE_W-1:0] trate_q;
  logic [mtsc_pkg::ACCEL_W-1:0] accel_q;
  logic [mtsc_pkg::GAIN_W-1:0]  gain_q;

  mtsc_in_if  in_if ();
  mtsc_out_if out_if ();
  mtsc_cfg_if cfg_if ();

  maze_turn_steering_controller u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #1 clk = ~clk;

  function automatic longint sat32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Advances the predictor by one word and returns the result it should give.
  function automatic nav_result_t predict_result(input nav_word_t w);
    longint      fr, lf, rt, gy, dtv, inc, step, err, eff;
    longint      wall_v, angle_v, trate_v, accel_v, gain_v, d2r;
    nav_result_t r;
    wall_v  = wall_q;
    angle_v = angle_q;
    trate_v = trate_q;
    accel_v = accel_q;
    gain_v  = gain_q;
    d2r     = mtsc_pkg::DEG2RAD_Q24;
    eff     = 0;
    if (w.cmd == CMD_STRATEGY) begin
      fr = w.front_d;
      lf = w.left_d;
      rt = w.right_d;
      case (mode_m)
        mtsc_pkg::NAV_START: begin
          mode_m = mtsc_pkg::NAV_FORWARD;
        end
        mtsc_pkg::NAV_FORWARD: begin
          goal_rate_m = 0;
          // A valid reading inside the threshold starts a turn to the roomier side.
          if (fr > 0 && fr < wall_v) begin
            if (lf > rt) begin
              mode_m      = mtsc_pkg::NAV_LEFT;
              goal_head_m = sat32(head_m + angle_v);
              goal_rate_m = trate_v;
            end else begin
              mode_m      = mtsc_pkg::NAV_RIGHT;
              goal_head_m = sat32(head_m - angle_v);
              goal_rate_m = -trate_v;
            end
          end
        end
        mtsc_pkg::NAV_LEFT: begin
          if (head_m >= goal_head_m) begin
            head_m      = goal_head_m;
            goal_rate_m = 0;
            mode_m      = mtsc_pkg::NAV_FORWARD;
          end
        end
        default: begin
          if (head_m <= goal_head_m) begin
            head_m      = goal_head_m;
            goal_rate_m = 0;
            mode_m      = mtsc_pkg::NAV_FORWARD;
          end
        end
      endcase
    end else begin
      gy  = w.gyro;
      dtv = w.dt;
      // Heading increment rounded half up from Q.48 to Q.20 radians.
      inc    = (gy * dtv * d2r + (longint'(1) <<< (mtsc_pkg::INC_SHIFT - 1)))
               >>> mtsc_pkg::INC_SHIFT;
      step   = (accel_v * dtv) >>> 16;
      head_m = sat32(head_m + inc);
      // Slew the commanded rate toward the goal without overshoot.
      if (slew_m < goal_rate_m) begin
        slew_m = slew_m + step;
        if (slew_m > goal_rate_m) slew_m = goal_rate_m;
      end else if (slew_m > goal_rate_m) begin
        slew_m = slew_m - step;
        if (slew_m < goal_rate_m) slew_m = goal_rate_m;
      end
      err = slew_m - gy;
      eff = sat32((err * gain_v + (longint'(1) <<< (mtsc_pkg::EFF_SHIFT - 1)))
                  >>> mtsc_pkg::EFF_SHIFT);
    end
    r.nav     = mode_m;
    r.effort  = eff[mtsc_pkg::EFF_W-1:0];
    r.heading = head_m[mtsc_pkg::HEAD_W-1:0];
    r.rate    = slew_m[mtsc_pkg::CRATE_W-1:0];
    return r;
  endfunction

  task automatic push_word(input logic cmd, input int f, input int l, input int r,
                           input int g, input int dt);
    nav_word_t w;
    w.cmd     = cmd;
    w.front_d = f[DW-1:0];
    w.left_d  = l[DW-1:0];
    w.right_d = r[DW-1:0];
    w.gyro    = g[RW-1:0];
    w.dt      = dt[mtsc_pkg::DT_W-1:0];
    word_q.push_back(w);
    words_left++;
    words_total++;
  endtask

  // A wall ahead, a few steering ticks mostly turning the right way, then
  // strategy words with a clear path so that the turn can finish.
  task automatic push_turn_episode();
    int near_d, lf, rt, dir, n, mag, far_n;
    near_d = (wall_q > 1) ? $urandom_range(1, wall_q - 1) : $urandom_range(1, 64);
    lf     = int'($urandom_range(0, 65535)) - 32768;
    rt     = ($urandom_range(0, 9) == 0) ? lf : int'($urandom_range(0, 65535)) - 32768;
    dir    = (lf > rt) ? 1 : -1;
    push_word(CMD_STRATEGY, near_d, lf, rt, int'($urandom), int'($urandom));
    n = $urandom_range(1, 6);
    repeat (n) begin
      mag = $urandom_range(0, 1) ? $urandom_range(0, 32768) : $urandom_range(0, 1 << 22);
      if ($urandom_range(0, 99) < 15) mag = -mag;
      push_word(CMD_STEER, int'($urandom), int'($urandom), int'($urandom), dir * mag,
                $urandom_range(0, 65535));
    end
    far_n = $urandom_range(1, 2);
    repeat (far_n) begin
      push_word(CMD_STRATEGY,
                $urandom_range(0, 1) ? int'($urandom_range(wall_q, 32767))
                                     : -int'($urandom_range(0, 32768)),
                int'($urandom), int'($urandom), int'($urandom), int'($urandom));
    end
  endtask

  // Waits until every queued word has been taken and every result checked.
  task automatic wait_idle();
    while (words_left != 0 || result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int count);
    int goal;
    goal = words_total + count;
    while (words_total < goal) begin
      if ($urandom_range(0, 99) < 25) begin
        push_word(1'($urandom_range(0, 1)), int'($urandom), int'($urandom),
                  int'($urandom), int'($urandom), int'($urandom));
      end else begin
        push_turn_episode();
      end
    end
    wait_idle();
  endtask

  task automatic write_reg(input mtsc_pkg::cfg_index_t idx, input int unsigned val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val[mtsc_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      mtsc_pkg::REG_WALL_DISTANCE: wall_q  = val[mtsc_pkg::WALL_W-1:0];
      mtsc_pkg::REG_TURN_ANGLE:    angle_q = val[mtsc_pkg::ANGLE_W-1:0];
      mtsc_pkg::REG_TURN_RATE:     trate_q = val[mtsc_pkg::TRATE_W-1:0];
      mtsc_pkg::REG_SLEW_LIMIT:    accel_q = val[mtsc_pkg::ACCEL_W-1:0];
      default:                     gain_q  = val[mtsc_pkg::GAIN_W-1:0];
    endcase
  endtask

  task automatic set_config(input int unsigned wall, input int unsigned angle,
                            input int unsigned trate, input int unsigned accel,
                            input int unsigned gain);
    write_reg(mtsc_pkg::REG_WALL_DISTANCE, wall);
    write_reg(mtsc_pkg::REG_TURN_ANGLE, angle);
    write_reg(mtsc_pkg::REG_TURN_RATE, trate);
    write_reg(mtsc_pkg::REG_SLEW_LIMIT, accel);
    write_reg(mtsc_pkg::REG_YAW_GAIN, gain);
  endtask

  // Word driver: offers the next queued word and predicts each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        result_q.push_back(predict_result(cur_word));
        words_left--;
      end
      if (!in_if.valid || in_if.ready) begin
        if (word_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_word = word_q.pop_front();
          in_if.valid          <= 1'b1;
          in_if.command        <= cur_word.cmd;
          in_if.front_distance <= cur_word.front_d;
          in_if.left_distance  <= cur_word.left_d;
          in_if.right_distance <= cur_word.right_d;
          in_if.gyro_rate      <= cur_word.gyro;
          in_if.time_step      <= cur_word.dt;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each taken result with the oldest prediction.
  always @(posedge clk) begin
    nav_result_t exp_r;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (result_q.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("unexpected result word: nav %0d effort %0d heading %0d rate %0d",
                     out_if.nav_state, out_if.turn_effort, out_if.heading,
                     out_if.commanded_rate);
        end else begin
          exp_r = result_q.pop_front();
          if (out_if.nav_state !== exp_r.nav || out_if.turn_effort !== exp_r.effort ||
              out_if.heading !== exp_r.heading || out_if.commanded_rate !== exp_r.rate) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display({"result mismatch: expected nav %0d effort %0d heading %0d ",
                        "rate %0d, got nav %0d effort %0d heading %0d rate %0d"},
                       exp_r.nav, exp_r.effort, exp_r.heading, exp_r.rate,
                       out_if.nav_state, out_if.turn_effort, out_if.heading,
                       out_if.commanded_rate);
          end
        end
        results_seen++;
        // Hold the result channel off for a long stretch once, to fill the block.
        if (results_seen == HOLD_AT) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int k;
    clk                  = 1'b0;
    rst_n                = 1'b0;
    calm                 = 1'b0;
    words_left           = 0;
    words_total          = 0;
    err_count            = 0;
    results_seen         = 0;
    hold_left            = 0;
    cycle_cnt            = 0;
    in_if.valid          = 1'b0;
    in_if.command        = CMD_STRATEGY;
    in_if.front_distance = '0;
    in_if.left_distance  = '0;
    in_if.right_distance = '0;
    in_if.gyro_rate      = '0;
    in_if.time_step      = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = mtsc_pkg::REG_WALL_DISTANCE;
    cfg_if.data          = '0;
    out_if.ready         = 1'b0;
    mode_m               = mtsc_pkg::NAV_START;
    head_m               = 0;
    goal_head_m          = 0;
    goal_rate_m          = 0;
    slew_m               = 0;
    wall_q               = mtsc_pkg::WALL_RST;
    angle_q              = mtsc_pkg::ANGLE_RST;
    trate_q              = mtsc_pkg::TRATE_RST;
    accel_q              = mtsc_pkg::ACCEL_RST;
    gain_q               = mtsc_pkg::GAIN_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset configuration.
    // The first strategy word only leaves the start state, even with a wall close.
    push_word(CMD_STRATEGY, 100, 0, 0, 0, 0);
    // No reading ahead, a hugely negative reading, and a reading on the threshold.
    push_word(CMD_STRATEGY, 0, 500, 100, 0, 0);
    push_word(CMD_STRATEGY, -32768, 500, 100, 0, 0);
    push_word(CMD_STRATEGY, 819, 500, 100, 0, 0);
    // Equal side ranges turn right.
    push_word(CMD_STRATEGY, 818, 1000, 1000, 0, 0);
    push_word(CMD_STEER, 0, 0, 0, -11520, 65535);
    push_word(CMD_STEER, 0, 0, 0, -11520, 65535);
    push_word(CMD_STRATEGY, 32767, 0, 0, 0, 0);
    push_word(CMD_STEER, 0, 0, 0, -11520, 65535);
    // A clear path after the turn has ended, then steering words with no rotation.
    push_word(CMD_STRATEGY, 32767, 0, 0, 0, 0);
    push_word(CMD_STEER, 0, 0, 0, 0, 0);
    push_word(CMD_STEER, 0, 0, 0, 0, 65535);
    // Left turn, then the heading is driven into positive saturation.
    push_word(CMD_STRATEGY, 1, 32767, -32768, 0, 0);
    for (k = 0; k < 4; k++) push_word(CMD_STEER, 0, 0, 0, 8388607, 65535);
    push_word(CMD_STRATEGY, 32767, 0, 0, 0, 0);
    // Right turn after the left turn has ended, with the most negative gyro rate.
    push_word(CMD_STRATEGY, 1, -32768, 32767, 0, 0);
    push_word(CMD_STEER, -1, -1, -1, -8388608, 65535);
    push_word(CMD_STRATEGY, 32767, 0, 0, 0, 0);
    push_word(CMD_STEER, 0, 0, 0, 8388607, 1);
    wait_idle();

    // All registers at their largest values.
    set_config(32767, 4194303, 524287, 524287, 65535);
    run_phase(PHASE_WORDS);

    // All registers at zero: no wall is ever near and nothing slews.
    set_config(0, 0, 0, 0, 0);
    run_phase(PHASE_WORDS);

    // Short turns, with neither side idling.
    calm <= 1'b1;
    set_config($urandom_range(1000, 32767), $urandom_range(1, 4096),
               $urandom_range(0, 524287), $urandom_range(0, 524287),
               $urandom_range(0, 65535));
    run_phase(PHASE_WORDS);
    calm <= 1'b0;

    // Random settings across the full register ranges.
    repeat (3) begin
      set_config($urandom_range(0, 32767), $urandom_range(0, 4194303),
                 $urandom_range(0, 524287), $urandom_range(0, 524287),
                 $urandom_range(0, 65535));
      run_phase(PHASE_WORDS);
    end

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[maze_turn_steering_controller.f]
hw/rtl/mtsc_pkg.sv
hw/rtl/mtsc_in_if.sv
hw/rtl/mtsc_out_if.sv
hw/rtl/mtsc_cfg_if.sv
hw/rtl/mtsc_ctrl.sv
hw/rtl/mtsc_datapath.sv
hw/rtl/maze_turn_steering_controller.sv
hw/rtl/mtsc_checker.sv
dv/maze_turn_steering_controller_tb.sv
